/* design/cdq_pkg.sv */
// Shared types, constants and index helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

   // Number of byte slots in the circular buffer.
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 8;
   localparam int LEN_W = 5;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Operation requested by one item.
   typedef enum logic [1:0] {
      FUNC_PUSH_TOP    = 2'd0,
      FUNC_PUSH_BOTTOM = 2'd1,
      FUNC_POP_TOP     = 2'd2,
      FUNC_POP_BOTTOM  = 2'd3
   } func_type;

   // Outcome reported with every result item.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Step an index up by one slot with wraparound.
   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   // Step an index down by one slot with wraparound.
   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - IDX_W'(1);
   endfunction

   // Occupancy as reported on the length field, modulo 32.
   function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
      logic [CNT_W+LEN_W-1:0] ext;
      ext = {{LEN_W{1'b0}}, c};
      return ext[LEN_W-1:0];
   endfunction

endpackage

/* design/cdq_if.sv */
// Valid/ready channel interfaces for deque requests and responses.
`timescale 1ns / 1ps

interface cdq_req_if;
   logic              valid;
   logic              ready;
   cdq_pkg::func_type func;
   logic [7:0]        value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic                valid;
   logic                ready;
   logic [7:0]          data;
   cdq_pkg::status_type status;
   logic [4:0]          length;

   modport source (output valid, output data, output status, output length, input ready);
   modport sink (input valid, input data, input status, input length, output ready);
endinterface

/* design/cdq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/circular_deque_unit.sv */
// Top level of the circular deque: pointers, occupancy, slot RAM and response register.
`timescale 1ns / 1ps

// Double-ended byte queue of cdq_pkg::DEPTH slots kept in a single-port-read
// RAM. A push, or any refused operation (push when full, pop when empty), has
// its result loaded into the response register at the edge where the item is
// accepted. A successful pop passes through ST_READ, because the slot is read
// through the registered read port of the RAM and the byte reaches the
// response register in the cycle after the read. A new item is taken as soon
// as the response register is free or is being emptied in the same cycle and
// no popped byte is in flight, so pushes run at one item per cycle; a pop
// holds off the next item until its byte is loaded. The slot RAM is not
// cleared after reset; a pop only ever reads slots that a push has written.
module circular_deque_unit (
   input  logic          clock,
   input  logic          reset,
   cdq_req_if.sink       req_if,
   cdq_rsp_if.source     rsp_if
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                    state_ff, state_in;
   logic [cdq_pkg::IDX_W-1:0]    top_ff, top_in;
   logic [cdq_pkg::IDX_W-1:0]    bottom_ff, bottom_in;
   logic [cdq_pkg::CNT_W-1:0]    occ_ff, occ_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::DATA_W-1:0]   data_ff, data_in;
   cdq_pkg::status_type          status_ff, status_in;
   logic [cdq_pkg::LEN_W-1:0]    length_ff, length_in;

   logic                         accept;
   logic                         is_full;
   logic                         is_empty;
   logic                         wr_en;
   logic [cdq_pkg::IDX_W-1:0]    wr_addr;
   logic                         rd_en;
   logic [cdq_pkg::IDX_W-1:0]    rd_addr;
   logic [cdq_pkg::DATA_W-1:0]   rd_data;

   // Slot storage.
   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_W),
      .DEPTH (cdq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshake: take an item only when idle and the response register frees up.
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign is_full      = (occ_ff == cdq_pkg::FULL_CNT);
   assign is_empty     = (occ_ff == '0);

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = data_ff;
   assign rsp_if.status = status_ff;
   assign rsp_if.length = length_ff;

   // Next-state logic for pointers, occupancy, RAM access and the response.
   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      length_in    = length_ff;
      wr_en        = 1'b0;
      wr_addr      = cdq_pkg::idx_dec(top_ff);
      rd_en        = 1'b0;
      rd_addr      = top_ff;

      if (rsp_if.valid && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in   = '0;
               status_in = cdq_pkg::STATUS_OK;
               case (req_if.func)
                  cdq_pkg::FUNC_PUSH_TOP: begin
                     if (is_full) begin
                        status_in = cdq_pkg::STATUS_FULL;
                     end else begin
                        top_in  = cdq_pkg::idx_dec(top_ff);
                        wr_en   = 1'b1;
                        wr_addr = cdq_pkg::idx_dec(top_ff);
                        occ_in  = occ_ff + cdq_pkg::CNT_W'(1);
                     end
                  end
                  cdq_pkg::FUNC_PUSH_BOTTOM: begin
                     if (is_full) begin
                        status_in = cdq_pkg::STATUS_FULL;
                     end else begin
                        bottom_in = cdq_pkg::idx_inc(bottom_ff);
                        wr_en     = 1'b1;
                        wr_addr   = cdq_pkg::idx_inc(bottom_ff);
                        occ_in    = occ_ff + cdq_pkg::CNT_W'(1);
                     end
                  end
                  cdq_pkg::FUNC_POP_TOP: begin
                     if (is_empty) begin
                        status_in = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_ff;
                        top_in   = cdq_pkg::idx_inc(top_ff);
                        occ_in   = occ_ff - cdq_pkg::CNT_W'(1);
                        state_in = ST_READ;
                     end
                  end
                  cdq_pkg::FUNC_POP_BOTTOM: begin
                     if (is_empty) begin
                        status_in = cdq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = bottom_ff;
                        bottom_in = cdq_pkg::idx_dec(bottom_ff);
                        occ_in    = occ_ff - cdq_pkg::CNT_W'(1);
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               length_in    = cdq_pkg::len_of(occ_in);
               rsp_valid_in = (state_in == ST_IDLE);
            end
         end
         ST_READ: begin
            // The popped byte arrives from the RAM read register.
            data_in      = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         bottom_ff    <= cdq_pkg::LAST_IDX;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff   <= data_in;
      status_ff <= status_in;
      length_ff <= length_in;
   end

   // Occupancy never exceeds the number of slots.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cdq_pkg::FULL_CNT)
      else $error("occupancy above capacity");

   // The response register is free while a popped byte is on its way.
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("response register busy during slot read");

   // A pending response always reports the current occupancy.
   a_length_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> length_ff == cdq_pkg::len_of(occ_ff))
      else $error("reported length differs from occupancy");

   // A successful pop is followed by the read-return cycle.
   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_empty && (req_if.func == cdq_pkg::FUNC_POP_TOP ||
                               req_if.func == cdq_pkg::FUNC_POP_BOTTOM))
      |=> state_ff == ST_READ)
      else $error("pop did not enter read state");

   // The RAM is never written and read in the same cycle.
   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("slot RAM written and read together");

endmodule
